// File: hw/rtl/nrsh_pkg.sv
// Package: widths, entry type, shared constants for the ray/segment hit block
`default_nettype none
package nrsh_pkg;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = 7;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [5:0]        slot;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic [15:0]        ray_fraction;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } seg_t;
endpackage
`default_nettype wire

// File: hw/rtl/nrsh_if.sv
// Interface: valid/ready channel carrying one word
`default_nettype none
interface nrsh_in_if;
  logic valid;
  logic ready;
  nrsh_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrsh_out_if;
  logic valid;
  logic ready;
  nrsh_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nrsh_seg_ram.sv
// Segment table: one write port, one registered read port
`default_nettype none
module nrsh_seg_ram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [nrsh_pkg::IdxW-1:0]  waddr_i,
  input  wire nrsh_pkg::seg_t             wdata_i,
  input  wire logic [nrsh_pkg::IdxW-1:0]  raddr_i,
  output nrsh_pkg::seg_t                  rdata_o
);
  nrsh_pkg::seg_t mem_q [nrsh_pkg::MaxSegments];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/nrsh_divider.sv
// Restoring divider: unsigned 64/34, one quotient bit per cycle
`default_nettype none
module nrsh_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [33:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [63:0] quo_q, quo_d;
  logic [34:0] rem_q, rem_d;
  logic [34:0] trial;
  logic [33:0] den_q, den_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[33:0], quo_q[63]} - {1'b0, den_q};
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // shift in next numerator bit, subtract when it fits
      if (!trial[34]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[33:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
      end
    end
    // done pulses once after the last step; a new start may come in the same cycle
    if (!busy_q && cnt_q == 7'd64) begin
      done_o = 1'b1;
      cnt_d  = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

// File: hw/rtl/nearest_ray_segment_hit.sv
// Top level: segment table, scan pipeline, nearest-hit compare, final divisions
//
//  channel  | dir | handshake     | payload
//  in_if    | in  | valid/ready   | mode, slot, first_x/y, second_x/y
//  out_if   | out | valid/ready   | hit, hit_x, hit_y, ray_fraction
//  cfg      | in  | cfg_we_i      | segment_count (7 bits)
//
// A cast scans one table entry per cycle through the memory read port and a
// three-stage product pipeline, then runs three divisions on one shared divider
// when a hit was found. Reset clears control state only.
// A waiting result holds in the output register; the next word is taken only
// after it leaves.
`default_nettype none
module nearest_ray_segment_hit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nrsh_in_if.sink       in_if,
  nrsh_out_if.source    out_if,
  input  wire logic     cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIVX = 3'd3;
  localparam logic [2:0] ST_DIVY = 3'd4;
  localparam logic [2:0] ST_DIVF = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  localparam int unsigned IW = nrsh_pkg::IdxW;

  logic [2:0] st_q, st_d;
  logic [6:0] cnt_q;
  logic [6:0] limit;
  logic [IW:0] rd_q, rd_d;
  logic [3:0] vld_q;
  logic signed [15:0] px_q, py_q, rx_q, ry_q;
  logic signed [16:0] dx_q, dy_q;
  nrsh_pkg::seg_t rdata;
  nrsh_pkg::seg_t wseg;
  logic we;
  // stage 1 registers
  logic signed [16:0] ex_q, ey_q, wx_q, wy_q;
  // stage 2 products
  logic signed [33:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  // stage 3
  logic signed [34:0] den_s, nt_s, nu_s;
  logic [34:0] aden, ant, anu;
  logic ok;
  logic found_q;
  logic [33:0] bn_q, bd_q;
  logic [67:0] c1, c2;
  logic better;
  logic [33:0] cn_q, cd_q;
  logic cv_q;
  // division
  logic div_start;
  logic [63:0] div_num;
  logic [33:0] div_den;
  logic div_done;
  logic [63:0] div_quo;
  logic signed [50:0] prod;
  logic neg_q;
  nrsh_pkg::out_word_t out_q;
  logic ov_q;

  assign limit = (cnt_q > 7'(nrsh_pkg::MaxSegments)) ? 7'(nrsh_pkg::MaxSegments) : cnt_q;
  assign in_if.ready = (st_q == ST_IDLE) && !ov_q;
  assign we = in_if.valid && in_if.ready && (in_if.data.mode == nrsh_pkg::MODE_WRITE);
  assign wseg = '{x1: in_if.data.first_x, y1: in_if.data.first_y,
                  x2: in_if.data.second_x, y2: in_if.data.second_y};

  nrsh_seg_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_if.data.slot[IW-1:0]),
    .wdata_i (wseg),
    .raddr_i (rd_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 7'd0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // scan pipeline: read, differences, products, test
  always_ff @(posedge clk_i) begin
    ex_q <= 17'(rdata.x2) - 17'(rdata.x1);
    ey_q <= 17'(rdata.y2) - 17'(rdata.y1);
    wx_q <= 17'(rdata.x1) - 17'(px_q);
    wy_q <= 17'(rdata.y1) - 17'(py_q);
    p1_q <= dx_q * ey_q;
    p2_q <= dy_q * ex_q;
    p3_q <= wx_q * ey_q;
    p4_q <= wy_q * ex_q;
    p5_q <= wx_q * dy_q;
    p6_q <= wy_q * dx_q;
  end

  always_comb begin
    den_s = 35'(p1_q) - 35'(p2_q);
    nt_s  = 35'(p3_q) - 35'(p4_q);
    nu_s  = 35'(p5_q) - 35'(p6_q);
    if (den_s < 0) begin
      aden = 35'(-den_s); ant = 35'(-nt_s); anu = 35'(-nu_s);
    end else begin
      aden = den_s; ant = nt_s; anu = nu_s;
    end
    ok = vld_q[2] && (den_s != 0) && !ant[34] && !anu[34]
         && (ant <= aden) && (anu <= aden);
  end

  // candidate registered before compare
  always_ff @(posedge clk_i) begin
    cn_q <= ant[33:0];
    cd_q <= aden[33:0];
  end

  // compare candidate against the current best, so back-to-back hits see each other
  always_comb begin
    c1 = cn_q * bd_q;
    c2 = bn_q * cd_q;
    better = cv_q && (!found_q || c1 < c2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
      vld_q <= '0;
    end else begin
      cv_q <= ok;
      vld_q <= {vld_q[2:0], (st_q == ST_SCAN) && (rd_q < {1'b0, limit[IW-1:0]} ||
               (limit[6:IW] != 0 && rd_q < (IW+1)'(nrsh_pkg::MaxSegments)))};
    end
  end

  // divider operands by phase
  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = bd_q;
    prod = '0;
    if (st_q == ST_DRAIN && vld_q == '0 && !cv_q && found_q) begin
      div_start = 1'b1;
      prod = 51'(signed'(bn_q)) * 51'(dx_q);
    end else if (st_q == ST_DIVX && div_done) begin
      div_start = 1'b1;
      prod = 51'(signed'(bn_q)) * 51'(dy_q);
    end else if (st_q == ST_DIVY && div_done) begin
      div_start = 1'b1;
      prod = 51'(signed'({bn_q, 16'd0}));
    end
    div_num = prod[50] ? 64'(-prod) : 64'(prod);
  end

  nrsh_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    st_d = st_q;
    rd_d = rd_q;
    case (st_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready && in_if.data.mode == nrsh_pkg::MODE_CAST) begin
          st_d = ST_SCAN;
          rd_d = '0;
        end
      end
      ST_SCAN: begin
        rd_d = rd_q + 1'b1;
        if (rd_q >= (limit > 7'(nrsh_pkg::MaxSegments - 1) ?
            (IW+1)'(nrsh_pkg::MaxSegments - 1) : (IW+1)'(limit))) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (vld_q == '0 && !cv_q) begin
          st_d = found_q ? ST_DIVX : ST_OUT;
        end
      end
      ST_DIVX: if (div_done) st_d = ST_DIVY;
      ST_DIVY: if (div_done) st_d = ST_DIVF;
      ST_DIVF: if (div_done) st_d = ST_OUT;
      ST_OUT: begin
        if (!ov_q) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      rd_q <= '0;
      found_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rd_q <= rd_d;
      if (st_q == ST_IDLE) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if (st_q == ST_OUT && !ov_q) begin
        ov_q <= 1'b1;
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // nearest hit and result assembly
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      px_q <= in_if.data.first_x;
      py_q <= in_if.data.first_y;
      rx_q <= in_if.data.second_x;
      ry_q <= in_if.data.second_y;
      dx_q <= 17'(in_if.data.second_x) - 17'(in_if.data.first_x);
      dy_q <= 17'(in_if.data.second_y) - 17'(in_if.data.first_y);
    end
    if (better) begin
      bn_q <= cn_q;
      bd_q <= cd_q;
    end
    if (div_start) begin
      neg_q <= prod[50];
    end
    if (st_q == ST_DRAIN && !found_q) begin
      out_q <= '{hit: 1'b0, hit_x: rx_q, hit_y: ry_q, ray_fraction: 16'hFFFF};
    end
    if (div_done && st_q == ST_DIVX) begin
      out_q.hit <= 1'b1;
      out_q.hit_x <= px_q + (neg_q ? 16'(-div_quo) : div_quo[15:0]);
    end
    if (div_done && st_q == ST_DIVY) begin
      out_q.hit_y <= py_q + (neg_q ? 16'(-div_quo) : div_quo[15:0]);
    end
    if (div_done && st_q == ST_DIVF) begin
      out_q.ray_fraction <= (div_quo > 64'd65535) ? 16'hFFFF : div_quo[15:0];
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data = out_q;
endmodule
`default_nettype wire

// File: hw/rtl/nrsh_checker.sv
// Checker on the top-level ports, bound to the top level
`default_nettype none
module nrsh_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_hit,
  input wire logic [15:0] out_frac
);
  // output valid holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  // no input taken while a result waits
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // a miss always reports full fraction
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_hit |-> out_frac == 16'hFFFF) else $error("miss fraction");
endmodule

bind nearest_ray_segment_hit nrsh_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_hit(out_if.data.hit), .out_frac(out_if.data.ray_fraction)
);
`default_nettype wire

// File: dv/tb_top.sv
// Testbench: nearest ray/segment hit block against a built-in hit predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  nrsh_in_if  in_ch ();
  nrsh_out_if out_ch ();

  nearest_ray_segment_hit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  nrsh_pkg::seg_t       wall_table [nrsh_pkg::MaxSegments];
  logic [6:0]           scan_count = '0;
  nrsh_pkg::out_word_t  pending_hits [$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  int unsigned cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("nearest_ray_segment_hit verification failed");
      $finish;
    end
  end

  // n1/d1 < n2/d2 exactly, nonnegative values
  function automatic bit ratio_below(longint n1, longint d1, longint n2, longint d2);
    logic [127:0] lhs, rhs;
    lhs = {64'd0, n1} * {64'd0, d2};
    rhs = {64'd0, n2} * {64'd0, d1};
    return lhs < rhs;
  endfunction

  // nearest hit of the ray against the first scan_count walls
  function automatic nrsh_pkg::out_word_t nearest_hit(nrsh_pkg::in_word_t w);
    longint px, py, dx, dy, ax, ay, ex, ey, wx, wy, den, nt, nu, best_n, best_d;
    int unsigned lim;
    bit found;
    nrsh_pkg::out_word_t r;
    px = w.first_x;  py = w.first_y;
    dx = longint'(w.second_x) - px;
    dy = longint'(w.second_y) - py;
    lim = (scan_count < nrsh_pkg::MaxSegments) ? scan_count : nrsh_pkg::MaxSegments;
    found = 1'b0;
    best_n = 0;
    best_d = 1;
    for (int i = 0; i < lim; i++) begin
      ax = wall_table[i].x1;  ay = wall_table[i].y1;
      ex = longint'(wall_table[i].x2) - ax;
      ey = longint'(wall_table[i].y2) - ay;
      wx = ax - px;  wy = ay - py;
      den = dx * ey - dy * ex;
      nt = wx * ey - wy * ex;
      nu = wx * dy - wy * dx;
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;  nt = -nt;  nu = -nu;
      end
      if (nt < 0 || nt > den || nu < 0 || nu > den) continue;
      // strict compare keeps the lowest index on ties
      if (!found || ratio_below(nt, den, best_n, best_d)) begin
        found = 1'b1;
        best_n = nt;
        best_d = den;
      end
    end
    if (!found) begin
      r.hit = 1'b0;
      r.hit_x = w.second_x;
      r.hit_y = w.second_y;
      r.ray_fraction = 16'hFFFF;
    end else begin
      r.hit = 1'b1;
      r.hit_x = 16'(px + (best_n * dx) / best_d);
      r.hit_y = 16'(py + (best_n * dy) / best_d);
      nt = (best_n * 65536) / best_d;
      r.ray_fraction = (nt > 65535) ? 16'hFFFF : 16'(nt);
    end
    return r;
  endfunction

  // input monitor: update table or queue the expected word
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (in_ch.data.mode == nrsh_pkg::MODE_WRITE) begin
        wall_table[in_ch.data.slot] = '{in_ch.data.first_x, in_ch.data.first_y,
                                        in_ch.data.second_x, in_ch.data.second_y};
      end else begin
        pending_hits.push_back(nearest_hit(in_ch.data));
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    nrsh_pkg::out_word_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_ch.data);
        errors++;
      end else begin
        exp_w = pending_hits.pop_front();
        if (exp_w.hit !== out_ch.data.hit)
          $display("%0t: hit exp %0d got %0d", $time, exp_w.hit, out_ch.data.hit);
        if (exp_w.hit_x !== out_ch.data.hit_x)
          $display("%0t: hit_x exp %0d got %0d", $time, exp_w.hit_x, out_ch.data.hit_x);
        if (exp_w.hit_y !== out_ch.data.hit_y)
          $display("%0t: hit_y exp %0d got %0d", $time, exp_w.hit_y, out_ch.data.hit_y);
        if (exp_w.ray_fraction !== out_ch.data.ray_fraction)
          $display("%0t: ray_fraction exp %0d got %0d", $time, exp_w.ray_fraction,
                   out_ch.data.ray_fraction);
        if (exp_w !== out_ch.data) errors++;
      end
    end
  end

  // receiver: random stalls, plus long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one word, with random idle cycles ahead of it
  task automatic send_word(nrsh_pkg::in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic put_wall(int slot, int x1, int y1, int x2, int y2);
    send_word('{nrsh_pkg::MODE_WRITE, 6'(slot), 16'(x1), 16'(y1), 16'(x2), 16'(y2)});
  endtask

  task automatic cast_ray(int x1, int y1, int x2, int y2);
    send_word('{nrsh_pkg::MODE_CAST, 6'($urandom), 16'(x1), 16'(y1), 16'(x2), 16'(y2)});
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  // register write only once the block has gone quiet
  task automatic set_count(int n);
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(n);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scan_count = 7'(n);
  endtask

  // coordinate: mostly near the origin so walls get hit, sometimes full range
  function automatic int pick_coord();
    if ($urandom_range(9) < 7) return $urandom_range(2048) - 1024;
    return $urandom_range(65535) - 32768;
  endfunction

  task automatic random_wall(int slot);
    int x1, y1, x2, y2;
    x1 = pick_coord();  y1 = pick_coord();
    case ($urandom_range(9))
      0: begin x2 = x1; y2 = y1; end              // point wall
      1: begin x2 = pick_coord(); y2 = y1; end    // axis aligned
      default: begin x2 = pick_coord(); y2 = pick_coord(); end
    endcase
    put_wall(slot, x1, y1, x2, y2);
  endtask

  task automatic random_ray();
    int x1, y1;
    x1 = pick_coord();  y1 = pick_coord();
    case ($urandom_range(19))
      0: cast_ray(x1, y1, x1, y1);                      // point ray
      1: cast_ray(wall_table[0].x1, wall_table[0].y1,   // starts on a wall end
                  pick_coord(), pick_coord());
      default: cast_ray(x1, y1, pick_coord(), pick_coord());
    endcase
  endtask

  // directed: empty table, special geometry, extremes
  task automatic test_directed();
    cast_ray(-32768, -32768, 32767, 32767);
    cast_ray(100, -50, 100, -50);
    put_wall(0, 0, 0, 0, 160);
    put_wall(1, 0, 0, 0, 160);              // duplicate wall, tie on index
    put_wall(2, -320, 80, 320, 80);         // collinear with the ray
    put_wall(3, -80, 80, -80, 80);          // point wall
    put_wall(4, 160, 80, 160, 200);         // touched at the ray end
    put_wall(5, -32768, -32768, 32767, 32767);
    put_wall(63, 32767, -32768, -32768, 32767);
    set_count(6);
    cast_ray(-160, 80, 160, 80);
    cast_ray(80, 80, 160, 80);              // starts on wall 5, zero fraction
    cast_ray(-32768, 32767, 32767, -32768);
    cast_ray(-7, 33, -7, 33);
    cast_ray(32767, -32768, 1000, 1001);
    cast_ray(-5, 300, -5, -300);
  endtask

  task automatic test_fill_table();
    for (int s = 0; s < nrsh_pkg::MaxSegments; s++) random_wall(s);
  endtask

  task automatic test_random(int n, int count_val, int idle_pct, int stall_pct);
    set_count(count_val);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      if ($urandom_range(4) == 0) random_wall($urandom_range(63));
      else random_ray();
    end
  endtask

  // receiver holds off while casts keep coming, then the sender waits it out
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 3000;
    repeat (12) random_ray();
    wait_drained();
    repeat (8) random_ray();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_random(200, 64, 0, 0);
    test_random(200, 127, 76, 0);
    test_random(200, $urandom_range(1, 63), 0, 76);
    test_random(200, 1, 7, 7);
    test_random(60, 0, 7, 7);
    test_backpressure();
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("nearest_ray_segment_hit verification clean");
    end else begin
      $display("nearest_ray_segment_hit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/nrsh_pkg.sv
hw/rtl/nrsh_if.sv
hw/rtl/nrsh_seg_ram.sv
hw/rtl/nrsh_divider.sv
hw/rtl/nearest_ray_segment_hit.sv
hw/rtl/nrsh_checker.sv
dv/tb_top.sv
